// File: rtl/rotatable_stack_store_assert.svh
// ----------------------------------------------------------------------------
// rotatable_stack_store_assert.svh
// assertion macros for the rotatable stack store, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ROTATABLE_STACK_STORE_ASSERT_SVH
`define ROTATABLE_STACK_STORE_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define RSS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rotatable_stack_store: assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define RSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rotatable_stack_store: assertion failed");
`else
`define RSS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define RSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared types and constants of the rotatable stack store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rss_pkg;

  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int MAG_W    = 16;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 9;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_READ   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_ROTATE = 3'd4
  } req_e;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_DIV,
    S_ROT_LOAD,
    S_ROT_MOVE,
    S_RESP
  } state_e;

endpackage

// File: rtl/rss_mod_unit.sv
// ----------------------------------------------------------------------------
// rss_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_mod_unit import rss_pkg::*; #(
  parameter int CW = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MAG_W-1:0]  dividend_i,
  input  logic [CW-1:0]     divisor_i,
  output logic              done_o,
  output logic [CW-1:0]     rem_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [CW-1:0]    rem_q, rem_d;
  logic [MAG_W-1:0] dvd_q;
  logic [CW:0]      shifted;
  logic [CW:0]      divisor_ext;

  // one shift and conditional subtract
  always_comb begin
    shifted     = {rem_q, dvd_q[MAG_W-1]};
    divisor_ext = {1'b0, divisor_i};
    if (shifted >= divisor_ext) begin
      rem_d = CW'(shifted - divisor_ext);
    end else begin
      rem_d = shifted[CW-1:0];
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(MAG_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder and dividend shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/rotatable_stack_store.sv
// From acceptance to result, push and write pass S_EXEC and S_RESP; pop and read pass S_RDWAIT too.
// Rotate of n held words by nonzero k runs the 16-step remainder unit; unless k reduces to 0,
// S_ROT_LOAD fetches each leader and S_ROT_MOVE does one store read-modify-write per moved word.
// One transaction is worked at a time; the next can be taken in the cycle after the result is
// latched, and S_RESP holds the result back while the output register waits.
// Reset clears count and control state; stored words undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// rotatable_stack_store
// fixed-capacity word store with push, pop, indexed read/write and rotation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rotatable_stack_store_assert.svh"

module rotatable_stack_store import rss_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic signed [WORD_W-1:0]   value_i,
  input  logic [INDEX_W-1:0]         index_i,
  input  logic signed [MAG_W-1:0]    amount_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [WORD_W-1:0]   result_word_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [HELD_W-1:0]          held_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

  state_e state_q, state_d;

  // captured transaction
  logic [REQ_W-1:0]    req_q, req_d;
  logic [WORD_W-1:0]   value_q, value_d;
  logic [INDEX_W-1:0]  index_q, index_d;
  logic [MAG_W-1:0]    amount_q, amount_d;

  // count, result and rotation registers
  logic [CW-1:0]       count_q, count_d;
  logic [WORD_W-1:0]   res_word_q, res_word_d;
  status_e             res_status_q, res_status_d;
  logic [CW-1:0]       k_q, k_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       start_q, start_d;
  logic [CW-1:0]       moves_q, moves_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_word_q, out_word_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [HELD_W-1:0]   out_held_q, out_held_d;

  // store
  logic [WORD_W-1:0]   store_q [CAPACITY];
  logic [WORD_W-1:0]   rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata;

  // remainder unit
  logic                mod_start, mod_done;
  logic [MAG_W-1:0]    mag;
  logic [CW-1:0]       mod_rem;

  logic                in_fire;
  logic [IW-1:0]       idx_w, cnt_w;
  logic                idx_bad;
  logic [CW:0]         rot_sum;
  logic [CW-1:0]       rot_dst;

  assign in_fire = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // rotate magnitude, taken as two's complement negation for left moves
  assign mag = amount_q[MAG_W-1] ? (MAG_W'(0) - amount_q) : amount_q;

  // index range check
  assign idx_w   = IW'(index_q);
  assign cnt_w   = IW'(count_q);
  assign idx_bad = (idx_w >= cnt_w);

  // next rotation target, pos and k are both below the count
  assign rot_sum = {1'b0, pos_q} + {1'b0, k_q};
  assign rot_dst = (rot_sum >= {1'b0, count_q}) ? CW'(rot_sum - {1'b0, count_q})
                                                 : rot_sum[CW-1:0];

  rss_mod_unit #(
    .CW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mag),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // sequencer next state and datapath control
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    value_d      = value_q;
    index_d      = index_q;
    amount_d     = amount_q;
    count_d      = count_q;
    res_word_d   = res_word_q;
    res_status_d = res_status_q;
    k_d          = k_q;
    pos_d        = pos_q;
    start_d      = start_q;
    moves_d      = moves_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    out_held_d   = out_held_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    mem_wdata    = value_q;
    mod_start    = 1'b0;

    // output side handshake
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d        = req_type_i;
          value_d      = value_i;
          index_d      = index_i;
          amount_d     = amount_i;
          res_word_d   = '0;
          res_status_d = ST_OK;
          state_d      = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_RESP;
        case (req_q)
          REQ_PUSH: begin
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_q);
              count_d   = count_q + 1'b1;
            end
          end
          REQ_POP: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(count_q - 1'b1);
              count_d   = count_q - 1'b1;
              state_d   = S_RDWAIT;
            end
          end
          REQ_READ: begin
            if (idx_bad) begin
              res_status_d = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(idx_w);
              state_d   = S_RDWAIT;
            end
          end
          REQ_WRITE: begin
            if (idx_bad) begin
              res_status_d = ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(idx_w);
            end
          end
          REQ_ROTATE: begin
            if (count_q > CW'(1)) begin
              mod_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        res_word_d = rd_q;
        state_d    = S_RESP;
      end

      // wait for the reduced distance, turn left moves into right moves
      S_DIV: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            state_d = S_RESP;
          end else begin
            k_d     = amount_q[MAG_W-1] ? (count_q - mod_rem) : mod_rem;
            pos_d   = '0;
            start_d = '0;
            moves_d = count_q;
            state_d = S_ROT_LOAD;
          end
        end
      end

      // fetch the leader of the next cycle of the permutation
      S_ROT_LOAD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(start_q);
        state_d   = S_ROT_MOVE;
      end

      // carried word goes to its target, displaced word becomes the carry
      S_ROT_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(rot_dst);
        mem_wdata = rd_q;
        mem_re    = 1'b1;
        mem_raddr = AW'(rot_dst);
        moves_d   = moves_q - 1'b1;
        pos_d     = rot_dst;
        if (rot_dst == start_q) begin
          if (moves_q == CW'(1)) begin
            state_d = S_RESP;
          end else begin
            start_d = start_q + 1'b1;
            pos_d   = start_q + 1'b1;
            state_d = S_ROT_LOAD;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_word_d   = res_word_q;
          out_status_d = res_status_q;
          out_held_d   = HELD_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    value_q      <= value_d;
    index_q      <= index_d;
    amount_q     <= amount_d;
    res_word_q   <= res_word_d;
    res_status_q <= res_status_d;
    k_q          <= k_d;
    pos_q        <= pos_d;
    start_q      <= start_d;
    moves_q      <= moves_d;
    out_word_q   <= out_word_d;
    out_status_q <= out_status_d;
    out_held_q   <= out_held_d;
  end

  // word store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_word_o = out_word_q;
  assign status_o      = out_status_q;
  assign held_count_o  = out_held_q;

  // checks
  `RSS_ASSERT_IMPLY(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY))
  `RSS_ASSERT_NEXT(a_one_transaction, clk_i, rst_ni, in_fire, !in_ready_o)
  `RSS_ASSERT_NEXT(a_rotate_keeps_count, clk_i, rst_ni, state_q == S_ROT_MOVE, $stable(count_q))
  `RSS_ASSERT_IMPLY(a_mod_done_in_div, clk_i, rst_ni, mod_done, state_q == S_DIV)

endmodule

// File: tb/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker
// watches both channels of the rotatable stack store, predicts each reply and
// compares it field by field against what the block returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_checker import rss_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [WORD_W-1:0]   value_i,
  input  logic [INDEX_W-1:0]  index_i,
  input  logic [MAG_W-1:0]    amount_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [WORD_W-1:0]   result_word_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [HELD_W-1:0]   held_count_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_e           status;
    logic [HELD_W-1:0] held;
  } stack_reply_t;

  // shadow copy of the store contents and fill level
  logic [WORD_W-1:0] word_mem [CAPACITY];
  int unsigned       word_count;
  stack_reply_t      pending_replies [$];
  int                fail_tally;
  int                reply_seq;

  // apply one request to the shadow store and return the reply it produces
  function automatic stack_reply_t apply_request(input logic [REQ_W-1:0]   req,
                                                 input logic [WORD_W-1:0]  val,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [MAG_W-1:0]   amt);
    stack_reply_t      reply;
    logic [WORD_W-1:0] rotated [CAPACITY];
    int unsigned       n;
    int unsigned       mag;
    int unsigned       shift;
    reply.word   = '0;
    reply.status = ST_OK;
    n            = word_count;
    case (req)
      REQ_PUSH: begin
        if (n >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          word_mem[n] = val;
          word_count  = n + 1;
        end
      end
      REQ_POP: begin
        if (n == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          word_count = n - 1;
          reply.word = word_mem[n-1];
        end
      end
      REQ_READ: begin
        if (idx >= n) reply.status = ST_RANGE;
        else reply.word = word_mem[idx];
      end
      REQ_WRITE: begin
        if (idx >= n) reply.status = ST_RANGE;
        else word_mem[idx] = val;
      end
      REQ_ROTATE: begin
        if (n > 1) begin
          // negative distance rotates left, i.e. right by the complement
          mag   = amt[MAG_W-1] ? (32'h10000 - 32'(amt)) : 32'(amt);
          shift = mag % n;
          if (amt[MAG_W-1] && shift != 0) shift = n - shift;
          if (shift != 0) begin
            for (int unsigned j = 0; j < n; j++) rotated[(j + shift) % n] = word_mem[j];
            for (int unsigned j = 0; j < n; j++) word_mem[j] = rotated[j];
          end
        end
      end
      default: ;
    endcase
    reply.held = word_count[HELD_W-1:0];
    return reply;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    fail_tally++;
    $display("MISMATCH reply %0d: %s got 0x%0h expected 0x%0h",
             reply_seq, what, got, want);
  endtask

  // compare replies first, then record the new transaction's prediction
  always @(posedge clk_i or negedge rst_ni) begin
    stack_reply_t want;
    if (!rst_ni) begin
      word_count = 0;
      pending_replies.delete();
      fail_tally = 0;
      reply_seq  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("reply with none pending", result_word_i, '0);
        end else begin
          want = pending_replies.pop_front();
          if (result_word_i !== want.word)
            report_mismatch("result_word", result_word_i, want.word);
          if (status_i !== want.status)
            report_mismatch("status", WORD_W'(status_i), WORD_W'(want.status));
          if (held_count_i !== want.held)
            report_mismatch("held_count", WORD_W'(held_count_i), WORD_W'(want.held));
        end
        reply_seq++;
      end
      if (in_valid_i && in_ready_i)
        pending_replies.insert(pending_replies.size(),
                               apply_request(req_type_i, value_i, index_i, amount_i));
      fail_count_o <= fail_tally;
      pending_o    <= pending_replies.size();
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the rotatable stack store: directed corner cases, then long
// random request sequences steered toward changing fill targets, with bursty
// sender, stalling receiver and a watchdog; checking is done by rss_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rss_pkg::*;

  localparam int CAPACITY      = 256;
  localparam int ITEM_TOTAL    = 1850;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 600;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 300;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;
  localparam logic [MAG_W-1:0]  DIST_MIN  = 16'h8000;
  localparam logic [MAG_W-1:0]  DIST_MAX  = 16'h7fff;
  localparam logic [MAG_W-1:0]  DIST_NEG1 = 16'hffff;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [REQ_W-1:0]   req_type     = REQ_PUSH;
  logic [WORD_W-1:0]  value        = '0;
  logic [INDEX_W-1:0] index        = '0;
  logic [MAG_W-1:0]   amount       = '0;
  logic               out_valid;
  logic               result_ready = 1'b0;
  logic [WORD_W-1:0]  result_word;
  logic [STATUS_W-1:0] status;
  logic [HELD_W-1:0]  held_count;
  int                 fail_total;
  int                 replies_pending;

  int                 burst_left   = 0;
  int unsigned        shadow_count = 0;
  int                 idle_cycles  = 0;

  rotatable_stack_store #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .value_i      (value),
    .index_i      (index),
    .amount_i     (amount),
    .out_valid_o  (out_valid),
    .out_ready_i  (result_ready),
    .result_word_o(result_word),
    .status_o     (status),
    .held_count_o (held_count)
  );

  rss_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_type_i   (req_type),
    .value_i      (value),
    .index_i      (index),
    .amount_i     (amount),
    .out_valid_i  (out_valid),
    .out_ready_i  (result_ready),
    .result_word_i(result_word),
    .status_i     (status),
    .held_count_i (held_count),
    .fail_count_o (fail_total),
    .pending_o    (replies_pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // offer one transaction, idling between bursts, and wait for its acceptance
  task automatic issue_request(input logic [REQ_W-1:0]   req,
                               input logic [WORD_W-1:0]  val,
                               input logic [INDEX_W-1:0] idx,
                               input logic [MAG_W-1:0]   amt);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    req_type <= req;
    value    <= val;
    index    <= idx;
    amount   <= amt;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    if (req == REQ_PUSH && shadow_count < CAPACITY) shadow_count++;
    if (req == REQ_POP && shadow_count > 0) shadow_count--;
  endtask

  // stop offering until every reply has been returned
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (replies_pending != 0) @(posedge clk_i);
    burst_left = $urandom_range(1, 8);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // mostly in-range positions, some anywhere in the field
  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned n);
    if (n > 0 && $urandom_range(0, 99) < 85) return INDEX_W'($urandom_range(0, n - 1));
    return INDEX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [MAG_W-1:0] pick_distance(input int unsigned n);
    case ($urandom_range(0, 9))
      0:       return DIST_MIN;
      1:       return DIST_MAX;
      2:       return MAG_W'(n * $urandom_range(0, 3));
      3, 4:    return MAG_W'($urandom);
      default: return MAG_W'($urandom_range(0, 600) - 300);
    endcase
  endfunction

  // main stimulus
  initial begin
    int                 items;
    int unsigned        target;
    int                 seq_len;
    int                 r;
    logic               drained;
    logic [REQ_W-1:0]   req;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases on an empty, then tiny, store
    issue_request(REQ_POP, WORD_ONES, '0, '0);
    issue_request(REQ_ROTATE, '0, '0, 16'd5);
    issue_request(REQ_READ, '0, 8'd0, '0);
    issue_request(REQ_WRITE, WORD_MAX, 8'd255, '0);
    issue_request(REQ_SPARE_LO, WORD_ONES, 8'hff, DIST_NEG1);
    issue_request(REQ_SPARE_LO + 3'd1, WORD_ONES, 8'hff, DIST_NEG1);
    issue_request(REQ_SPARE_HI, WORD_ONES, 8'hff, DIST_NEG1);
    issue_request(REQ_PUSH, WORD_MIN, '0, '0);
    issue_request(REQ_PUSH, WORD_MAX, '0, '0);
    issue_request(REQ_PUSH, '0, '0, '0);
    issue_request(REQ_PUSH, WORD_ONES, '0, '0);
    issue_request(REQ_READ, '0, 8'd3, '0);
    issue_request(REQ_READ, '0, 8'd4, '0);
    issue_request(REQ_WRITE, 32'h5555_5555, 8'd1, '0);
    issue_request(REQ_READ, '0, 8'd1, '0);
    issue_request(REQ_ROTATE, '0, '0, 16'd1);
    issue_request(REQ_ROTATE, '0, '0, DIST_NEG1);
    issue_request(REQ_ROTATE, '0, '0, DIST_MIN);
    issue_request(REQ_ROTATE, '0, '0, DIST_MAX);
    issue_request(REQ_ROTATE, '0, '0, '0);
    issue_request(REQ_ROTATE, '0, '0, 16'd4);
    issue_request(REQ_READ, '0, 8'd0, '0);
    repeat (3) issue_request(REQ_POP, '0, '0, '0);
    issue_request(REQ_ROTATE, '0, '0, DIST_MIN);
    issue_request(REQ_POP, '0, '0, '0);

    // random sequences, each steering the fill level toward a target;
    // the first one fills the store to capacity
    items   = 0;
    drained = 1'b0;
    target  = CAPACITY;
    seq_len = 600;
    while (items < ITEM_TOTAL) begin
      repeat (seq_len) begin
        if (items < ITEM_TOTAL) begin
          if (!drained && items == ITEM_TOTAL / 2) begin
            drain_replies();
            drained = 1'b1;
          end
          r = $urandom_range(0, 99);
          if (r < 55) begin
            if (shadow_count < target) req = REQ_PUSH;
            else if (shadow_count > target) req = REQ_POP;
            else req = $urandom_range(0, 1) ? REQ_PUSH : REQ_POP;
          end else if (r < 67) begin
            req = REQ_READ;
          end else if (r < 79) begin
            req = REQ_WRITE;
          end else if (r < 95) begin
            req = REQ_ROTATE;
          end else begin
            req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
          end
          issue_request(req, pick_word(), pick_index(shadow_count),
                        pick_distance(shadow_count));
          items++;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 75) target = $urandom_range(0, 16);
      else if (r < 96) target = $urandom_range(17, 120);
      else target = CAPACITY;
      seq_len = (target == CAPACITY) ? 600 : $urandom_range(15, 60);
    end

    // let everything drain, then allow for a late stray reply
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (replies_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: stall patterns of varying density, plus one long hold-off
  initial begin
    int   mode;
    int   replies_taken;
    logic held_off;
    replies_taken = 0;
    held_off      = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk_i);
        if (out_valid && result_ready) replies_taken++;
        if (!held_off && replies_taken >= HOLD_AFTER) begin
          held_off = 1'b1;
          result_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end else begin
          case (mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && result_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
